[rtl/core/sm3_pkg.sv]
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round functions for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

	localparam int PadLimit   = 56;
	localparam int Rounds     = 64;
	localparam int CountW     = 61;

	localparam logic [31:0] TLow  = 32'h79CC4519;
	localparam logic [31:0] THigh = 32'h7A879D8A;
	localparam logic [7:0]  PadByte = 8'h80;

	localparam logic [255:0] Iv = {
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word0;
		logic [31:0] digest_word1;
		logic [31:0] digest_word2;
		logic [31:0] digest_word3;
		logic [31:0] digest_word4;
		logic [31:0] digest_word5;
		logic [31:0] digest_word6;
		logic [31:0] digest_word7;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       buf_we;
		logic [7:0] buf_data;
		logic       start;
		logic       reset_cv;
	} dp_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic busy;
		logic done;
	} dp_sts_t;

	function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
	endfunction

endpackage

[rtl/core/sm3_datapath.sv]
// ----------------------------------------------------------------------------
// SM3 datapath
// Block bytes shift into a 16-word window that then serves as the message
// schedule; one compression round per cycle, with the chaining value.
// ----------------------------------------------------------------------------
module sm3_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  sm3_pkg::dp_cmd_t cmd,
	output sm3_pkg::dp_sts_t sts,
	output logic [255:0]     cv
);

	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [255:0] cv_q;
	logic [5:0]   rnd_q;
	logic         busy_q;
	logic         done_q;

	logic [31:0] wnew, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
	logic        low;

	// Next schedule word and the round logic.
	always_comb begin
		low  = (rnd_q < 6'd16);
		wnew = sm3_pkg::p1(w_q[0] ^ w_q[7] ^ sm3_pkg::rol(w_q[13], 5'd15))
			^ sm3_pkg::rol(w_q[3], 5'd7) ^ w_q[10];
		tj   = sm3_pkg::rol(low ? sm3_pkg::TLow : sm3_pkg::THigh, rnd_q[4:0]);
		a12  = sm3_pkg::rol(a_q, 5'd12);
		ss1  = sm3_pkg::rol(a12 + e_q + tj, 5'd7);
		ss2  = ss1 ^ a12;
		ff   = low ? (a_q ^ b_q ^ c_q) : ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
		gg   = low ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
		tt1  = ff + d_q + ss2 + (w_q[0] ^ w_q[4]);
		tt2  = gg + h_q + ss1 + w_q[0];
	end

	// Block bytes enter at the bottom of the window, so after 64 writes the
	// first byte sits at the top of word 0. During a compression the window
	// slides one word per round.
	always_ff @(posedge clk) begin
		if (cmd.buf_we) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], cmd.buf_data};
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wnew;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= cv_q;
		end else if (busy_q) begin
			a_q <= tt1;
			b_q <= a_q;
			c_q <= sm3_pkg::rol(b_q, 5'd9);
			d_q <= c_q;
			e_q <= sm3_pkg::p0(tt2);
			f_q <= e_q;
			g_q <= sm3_pkg::rol(f_q, 5'd19);
			h_q <= g_q;
		end
	end

	// Round counter, chaining value and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q   <= sm3_pkg::Iv;
			rnd_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (rnd_q == 6'(sm3_pkg::Rounds - 1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(sm3_pkg::Rounds - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (cmd.reset_cv) begin
				cv_q <= sm3_pkg::Iv;
			end else if (done_q) begin
				cv_q <= cv_q ^ {a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q};
			end
		end
	end

	assign sts.busy = busy_q | done_q;
	assign sts.done = done_q;
	assign cv       = cv_q;

endmodule

[rtl/core/sm3_ctrl.sv]
// ----------------------------------------------------------------------------
// SM3 controller
// Takes byte transfers, fills the block buffer, runs padding and starts
// compressions; presents the digest in an output register.
// ----------------------------------------------------------------------------
module sm3_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  sm3_pkg::in_item_t in_item,
	input  logic              in_valid,
	output logic              in_stall,
	output sm3_pkg::out_item_t out_item,
	output logic              out_valid,
	input  logic              out_stall,
	output sm3_pkg::dp_cmd_t  cmd,
	input  sm3_pkg::dp_sts_t  sts,
	input  logic [255:0]      cv
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_WAIT, ST_PAD, ST_LEN, ST_FINAL, ST_OUT
	} state_t;

	state_t                     state_q, state_d;
	logic [sm3_pkg::CountW-1:0] count_q, count_d;
	logic [5:0]                 pos_q, pos_d;
	logic                       last_q, last_d;
	logic                       two_q, two_d;
	sm3_pkg::dp_cmd_t           cmd_d;

	logic        acc;
	logic        out_load;
	logic        out_valid_d;
	logic [63:0] bits_w;

	assign acc         = in_valid && !in_stall;
	assign in_stall    = (state_q != ST_IDLE);
	assign bits_w      = {count_q, 3'b000};
	assign out_valid_d = (out_valid && out_stall) || out_load;

	// Next state and commands. A block starts compressing on the same
	// cycle as its last byte write; two_q marks the first of two pad blocks.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		pos_d    = pos_q;
		last_d   = last_q;
		two_d    = two_q;
		cmd_d    = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_item.has_byte) begin
						cmd_d.buf_we   = 1'b1;
						cmd_d.buf_data = in_item.data_byte;
						count_d        = count_q + 1'b1;
					end
					last_d = in_item.is_last;
					if (in_item.has_byte && count_q[5:0] == 6'd63) begin
						cmd_d.start = 1'b1;
						state_d     = ST_WAIT;
					end else if (in_item.is_last) begin
						state_d = ST_PAD;
					end
				end
			end
			// A full message block is compressing.
			ST_WAIT: begin
				if (sts.done) begin
					state_d = last_q ? ST_PAD : ST_IDLE;
				end
			end
			// The pad byte; when it closes the block, compress right away.
			ST_PAD: begin
				cmd_d.buf_we   = 1'b1;
				cmd_d.buf_data = sm3_pkg::PadByte;
				pos_d          = count_q[5:0] + 6'd1;
				two_d          = (count_q[5:0] >= 6'(sm3_pkg::PadLimit));
				if (count_q[5:0] == 6'd63) begin
					cmd_d.start = 1'b1;
					state_d     = ST_FINAL;
				end else begin
					state_d = ST_LEN;
				end
			end
			// Zero fill, then the length bytes unless this block is the first of two.
			ST_LEN: begin
				cmd_d.buf_we = 1'b1;
				pos_d        = pos_q + 6'd1;
				if (!two_q && pos_q >= 6'(sm3_pkg::PadLimit)) begin
					cmd_d.buf_data = bits_w[8*(7-(pos_q[2:0]))+:8];
				end else begin
					cmd_d.buf_data = 8'h00;
				end
				if (pos_q == 6'd63) begin
					cmd_d.start = 1'b1;
					state_d     = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (sts.done) begin
					if (two_q) begin
						two_d   = 1'b0;
						pos_d   = 6'd0;
						state_d = ST_LEN;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_OUT: begin
				if (!out_valid) begin
					out_load       = 1'b1;
					cmd_d.reset_cv = 1'b1;
					count_d        = '0;
					last_d         = 1'b0;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			last_q    <= 1'b0;
			two_q     <= 1'b0;
			out_valid <= 1'b0;
			out_item  <= '0;
			cmd       <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			pos_q     <= pos_d;
			last_q    <= last_d;
			two_q     <= two_d;
			out_valid <= out_valid_d;
			cmd       <= cmd_d;
			if (out_load) begin
				out_item <= cv;
			end
		end
	end

endmodule

[rtl/core/sm3_hash_engine.sv]
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streams message bytes and returns the 256-bit SM3 digest per message.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle within a block; the 64th byte of a block
// stalls the input while the single round unit runs 64 rounds.
// Digest: registered after the message-end transfer, once the padding
// sweep and one or two compressions are done.
// Reset: chaining value returns to the SM3 initial value, count cleared.
module sm3_hash_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  sm3_pkg::in_item_t  in_item,
	input  logic               in_valid,
	output logic               in_stall,
	output sm3_pkg::out_item_t out_item,
	output logic               out_valid,
	input  logic               out_stall
);

	sm3_pkg::dp_cmd_t cmd;
	sm3_pkg::dp_sts_t sts;
	logic [255:0]     cv;

	sm3_ctrl u_ctrl (
		.clk, .arst_n, .in_item, .in_valid, .in_stall,
		.out_item, .out_valid, .out_stall, .cmd, .sts, .cv
	);

	sm3_datapath u_dp (.clk, .arst_n, .cmd, .sts, .cv);

	// No input is taken while a compression runs.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> in_stall) else $error("input accepted during compression");

	// The output register holds its digest while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("digest changed while stalled");

endmodule
